// File: hw/rtl/tea_pkg.sv
`default_nettype none

package tea_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned ROUNDS = 32;
    localparam int unsigned LATENCY = 2 * ROUNDS;
    localparam t_word DELTA = 32'h9e37_79b9;
    localparam logic [63:0] DELTA_TIMES_ROUNDS = 64'(DELTA) * 64'(ROUNDS);
    localparam t_word SUM_DEC_INIT = DELTA_TIMES_ROUNDS[31:0];

    localparam int unsigned KEY_WORDS = 4;

    typedef enum logic {
        CMD_ENC = 1'b0,
        CMD_DEC = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_reg_idx;

    typedef t_word [KEY_WORDS-1:0] t_key;

    // one block in flight, sum is the value this round mixes with
    typedef struct packed {
        t_cmd  cmd;
        t_word a;
        t_word b;
        t_word sum;
    } t_blk;

    function automatic t_word mix(t_word x, t_word sum, t_word ka, t_word kb);
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tea_round.sv
`default_nettype none

module tea_round
    import tea_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_key i_key,
    input  wire logic i_vld,
    input  wire t_blk i_blk,
    output logic      o_vld,
    output t_blk      o_blk
);

    logic r_vld_a;
    t_blk r_blk_a;
    t_blk n_blk_a;
    logic r_vld_b;
    t_blk r_blk_b;
    t_blk n_blk_b;

    // first half: encrypt updates a, decrypt undoes b
    always_comb begin
        n_blk_a = i_blk;
        if (i_blk.cmd == CMD_ENC) begin
            n_blk_a.a = i_blk.a + mix(i_blk.b, i_blk.sum, i_key[0], i_key[1]);
        end else begin
            n_blk_a.b = i_blk.b - mix(i_blk.a, i_blk.sum, i_key[2], i_key[3]);
        end
    end

    // second half plus the step of the running sum
    always_comb begin
        n_blk_b = r_blk_a;
        if (r_blk_a.cmd == CMD_ENC) begin
            n_blk_b.b   = r_blk_a.b + mix(r_blk_a.a, r_blk_a.sum, i_key[2], i_key[3]);
            n_blk_b.sum = r_blk_a.sum + DELTA;
        end else begin
            n_blk_b.a   = r_blk_a.a - mix(r_blk_a.b, r_blk_a.sum, i_key[0], i_key[1]);
            n_blk_b.sum = r_blk_a.sum - DELTA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk_a <= n_blk_a;
        r_blk_b <= n_blk_b;
    end

    assign o_vld = r_vld_b;
    assign o_blk = r_blk_b;

`ifndef SYNTH
    a_vld_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |-> ##2 o_vld)
        else $error("round lost an item");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_vld |-> ##2 !o_vld)
        else $error("round made up an item");

    a_cmd_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_a |=> (o_blk.cmd == $past(r_blk_a.cmd)))
        else $error("command changed inside round");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/tea_block_cipher_core.sv
// tea block cipher, 32 rounds, one round unrolled into two register stages
// each item passes through both register stages of every round in order, and the result is registered
// throughput: one item per cycle; o_busy never rises and the result cannot stall
// synchronous active-low reset clears all valid bits and the four key words to zero
// key writes take effect at the next edge and must not overlap items in flight
`default_nettype none

module tea_block_cipher_core
    import tea_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_command,
    input  wire logic [31:0] i_word_first,
    input  wire logic [31:0] i_word_second,
    output logic             o_done,
    output logic [31:0]      o_out_first,
    output logic [31:0]      o_out_second,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    t_key r_key;
    t_blk in_blk;
    logic in_vld;
    logic [ROUNDS:0] stage_vld;
    t_blk            stage_blk [ROUNDS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_KEY0: r_key[0] <= i_cfg_data;
                REG_KEY1: r_key[1] <= i_cfg_data;
                REG_KEY2: r_key[2] <= i_cfg_data;
                REG_KEY3: r_key[3] <= i_cfg_data;
                default:  r_key    <= r_key;
            endcase
        end
    end

    assign o_busy = 1'b0;
    assign in_vld = i_start && !o_busy;

    always_comb begin
        in_blk.cmd = t_cmd'(i_command);
        in_blk.a   = i_word_first;
        in_blk.b   = i_word_second;
        in_blk.sum = (t_cmd'(i_command) == CMD_ENC) ? DELTA : SUM_DEC_INIT;
    end

    assign stage_vld[0] = in_vld;
    assign stage_blk[0] = in_blk;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        tea_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_vld   (stage_vld[g]),
            .i_blk   (stage_blk[g]),
            .o_vld   (stage_vld[g+1]),
            .o_blk   (stage_blk[g+1])
        );
    end

    assign o_done       = stage_vld[ROUNDS];
    assign o_out_first  = stage_blk[ROUNDS].a;
    assign o_out_second = stage_blk[ROUNDS].b;

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_vld |-> ##LATENCY o_done)
        else $error("item did not come out after the pipeline latency");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_vld |-> ##LATENCY !o_done)
        else $error("result without an accepted item");

    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && t_reg_idx'(i_cfg_idx) == REG_KEY2) |=> (r_key[2] == $past(i_cfg_data)))
        else $error("key word write lost");
`endif

endmodule

`default_nettype wire
